// ----- design/periodic_oneshot_timer_table_top_defines.svh -----
// assertion macros for the timer table
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_TOP_DEFINES_SVH
`define POTT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
`define POTT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

// ----- design/pott_pkg.sv -----
// ----------------------------------------------------------------------------
// pott_pkg
// types and constants shared by the timer table modules
// ----------------------------------------------------------------------------
package pott_pkg;
    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_DELETED = 2'd1,
        ST_FIRED = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_SCAN,
        S_FIRE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic do_add;
        logic del_start;
        logic scan_start;
        logic scan_step;
        logic fire;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
    } stat_t;
endpackage

// ----- design/pott_if.sv -----
// ----------------------------------------------------------------------------
// pott_in_if / pott_out_if
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface pott_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [30:0] interval_ms;
    logic        periodic;
    logic [31:0] user_tag;
    logic [31:0] target_id;
    modport source (output valid, operation, interval_ms, periodic, user_tag, target_id,
                    input ready);
    modport sink (input valid, operation, interval_ms, periodic, user_tag, target_id,
                  output ready);
endinterface

interface pott_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] timer_id;
    logic [31:0] tag_out;
    logic        last;
    modport source (output valid, status, timer_id, tag_out, last, input ready);
    modport sink (input valid, status, timer_id, tag_out, last, output ready);
endinterface

// ----- design/pott_datapath.sv -----
// ----------------------------------------------------------------------------
// pott_datapath
// slot storage, time count, id counter and sequential expiry scan
// ----------------------------------------------------------------------------
module pott_datapath
    import pott_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  operation,
    input  logic [30:0] interval_ms,
    input  logic        periodic,
    input  logic [31:0] user_tag,
    input  logic [31:0] target_id,
    output logic [1:0]  res_status,
    output logic [31:0] res_id,
    output logic [31:0] res_tag
);
    logic [30:0] iv_reg;
    logic        per_reg;
    logic [31:0] tag_reg;
    logic [31:0] tid_reg;
    logic [1:0]  op_reg;
    logic [63:0] now_reg;
    logic [31:0] nid_reg;
    logic [NUM_SLOTS-1:0] used_reg;
    logic [31:0] sid_mem [NUM_SLOTS];
    logic [63:0] wake_mem [NUM_SLOTS];
    logic [30:0] ival_mem [NUM_SLOTS];
    logic        per_mem [NUM_SLOTS];
    logic [31:0] tag_mem [NUM_SLOTS];
    logic [SLOT_W-1:0] free_idx;
    logic              full;
    logic [CNT_W-1:0]  idx_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [63:0]       bwake_reg;
    logic [31:0]       bid_reg;
    logic [SLOT_W-1:0] cur;
    logic              cand;
    logic              better;
    logic [63:0]       add_wake;
    logic [63:0]       rel_wake;
    logic [1:0]        rs_reg;
    logic [31:0]       rid_reg;
    logic [31:0]       rtag_reg;

    always_comb
    begin
        free_idx = '0;
        full = 1'b1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SLOT_W'(i);
                full = 1'b0;
            end
        end
    end

    assign cur = idx_reg[SLOT_W-1:0];
    assign cand = used_reg[cur] && (wake_mem[cur] <= now_reg);
    assign better = !found_reg || (wake_mem[cur] < bwake_reg)
        || ((wake_mem[cur] == bwake_reg) && (sid_mem[cur] < bid_reg));
    assign add_wake = now_reg + 64'((iv_reg == '0) ? 31'd1 : iv_reg);
    assign rel_wake = now_reg + 64'((ival_mem[best_reg] == '0) ? 31'd1 : ival_mem[best_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            nid_reg <= 32'd1;
            used_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && (operation == OP_TICK))
            begin
                now_reg <= now_reg + 64'd1;
            end
            if (cmd.do_add && !full)
            begin
                used_reg[free_idx] <= 1'b1;
                nid_reg <= (nid_reg == 32'hFFFF_FFFF) ? 32'd1 : nid_reg + 32'd1;
            end
            if (cmd.del_start)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (used_reg[i] && (sid_mem[i] == tid_reg))
                    begin
                        used_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (cand && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.fire && !per_mem[best_reg])
            begin
                used_reg[best_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            iv_reg <= interval_ms;
            per_reg <= periodic;
            tag_reg <= user_tag;
            tid_reg <= target_id;
        end
        if (cmd.do_add && !full)
        begin
            sid_mem[free_idx] <= nid_reg;
            wake_mem[free_idx] <= add_wake;
            ival_mem[free_idx] <= iv_reg;
            per_mem[free_idx] <= per_reg;
            tag_mem[free_idx] <= tag_reg;
        end
        if (cmd.scan_step && cand && better)
        begin
            best_reg <= cur;
            bwake_reg <= wake_mem[cur];
            bid_reg <= sid_mem[cur];
        end
        if (cmd.fire && per_mem[best_reg])
        begin
            wake_mem[best_reg] <= rel_wake;
        end
        if (cmd.out_load)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    rs_reg <= full ? ST_FULL : ST_ADDED;
                    rid_reg <= full ? 32'd0 : nid_reg;
                    rtag_reg <= '0;
                end
                OP_DEL:
                begin
                    rs_reg <= ST_DELETED;
                    rid_reg <= tid_reg;
                    rtag_reg <= '0;
                end
                default:
                begin
                    rs_reg <= ST_FIRED;
                    rid_reg <= sid_mem[best_reg];
                    rtag_reg <= tag_mem[best_reg];
                end
            endcase
        end
    end

    assign stat.scan_done = (idx_reg == CNT_W'(NUM_SLOTS));
    assign stat.found = found_reg;
    assign res_status = rs_reg;
    assign res_id = rid_reg;
    assign res_tag = rtag_reg;
endmodule

// ----- design/pott_ctrl.sv -----
// ----------------------------------------------------------------------------
// pott_ctrl
// sequencer for add, delete and tick scan, plus result handshake
// ----------------------------------------------------------------------------
module pott_ctrl
    import pott_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_last,
    output cmd_t       cmd,
    input  stat_t      stat
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] nfire_reg, nfire_next;
    logic       ov_reg, ov_next;
    logic       last_reg, last_next;
    logic       pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nfire_reg <= '0;
            ov_reg <= 1'b0;
            last_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nfire_reg <= nfire_next;
            ov_reg <= ov_next;
            last_reg <= last_next;
            pend_reg <= pend_next;
        end
    end

    // a fired result is held one scan so its last flag is known
    always_comb
    begin
        state_next = state_reg;
        nfire_next = nfire_reg;
        ov_next = ov_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (op_t'(operation))
                        OP_ADD: state_next = S_ADD;
                        OP_DEL: state_next = S_DEL;
                        OP_TICK:
                        begin
                            nfire_next = '0;
                            pend_next = 1'b0;
                            cmd.scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (!ov_next)
                begin
                    cmd.out_load = 1'b1;
                    cmd.do_add = 1'b1;
                    ov_next = 1'b1;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEL:
            begin
                if (!ov_next)
                begin
                    cmd.out_load = 1'b1;
                    cmd.del_start = 1'b1;
                    ov_next = 1'b1;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (pend_reg)
                    begin
                        if (!ov_next)
                        begin
                            ov_next = 1'b1;
                            last_next = !stat.found || (nfire_reg == CNT_W'(MAX_RESULTS));
                            pend_next = 1'b0;
                        end
                    end
                    else if (stat.found && (nfire_reg != CNT_W'(MAX_RESULTS)))
                    begin
                        state_next = S_FIRE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                    if (pend_reg && !ov_next && (!stat.found
                        || (nfire_reg == CNT_W'(MAX_RESULTS))))
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FIRE:
            begin
                if (!ov_next)
                begin
                    cmd.out_load = 1'b1;
                    cmd.fire = 1'b1;
                    cmd.scan_start = 1'b1;
                    pend_next = 1'b1;
                    nfire_next = nfire_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_last = last_reg;
endmodule

// ----- design/periodic_oneshot_timer_table_top.sv -----
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table_top
// table of 32 software timers driven by tick items
//
// channel | dir | fields
// in      | in  | operation interval_ms periodic user_tag target_id
// out     | out | status timer_id tag_out last
//
// a tick scans every slot, one slot compared per cycle, with a full rescan
// after each fired timer
// reset clears time and slot use bits and sets the id counter to 1; no clearing pass
// a stalled result holds the sequencer at its next result load
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table_top
    import pott_pkg::*;
(
    input logic clk,
    input logic rst_n,
    pott_in_if.sink    in_ch,
    pott_out_if.source out_ch
);
    cmd_t  cmd;
    stat_t stat;
    logic [1:0] rs;

    pott_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .operation(in_ch.operation),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_last(out_ch.last), .cmd(cmd), .stat(stat)
    );

    pott_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .operation(in_ch.operation), .interval_ms(in_ch.interval_ms),
        .periodic(in_ch.periodic), .user_tag(in_ch.user_tag),
        .target_id(in_ch.target_id),
        .res_status(rs), .res_id(out_ch.timer_id), .res_tag(out_ch.tag_out)
    );

    assign out_ch.status = rs;
endmodule

// ----- design/pott_checker.sv -----
// ----------------------------------------------------------------------------
// pott_checker
// port-level checks on the timer table
// ----------------------------------------------------------------------------
`include "periodic_oneshot_timer_table_top_defines.svh"
module pott_checker
    import pott_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  operation,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] timer_id,
    input logic [31:0] tag_out,
    input logic        last
);
    `POTT_ASSERT_IMPL(a_tag_zero, clk, rst_n, out_valid && status != ST_FIRED, tag_out == 32'd0, "tag on non-fire")
    `POTT_ASSERT_IMPL(a_full_id, clk, rst_n, out_valid && status == ST_FULL, timer_id == 32'd0 && last, "bad full result")
    `POTT_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready && operation != OP_NONE, !in_ready, "accepted twice")
    `POTT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(timer_id), "result dropped")
endmodule

bind periodic_oneshot_timer_table_top pott_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .operation(in_ch.operation),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .timer_id(out_ch.timer_id),
    .tag_out(out_ch.tag_out), .last(out_ch.last)
);
